// ===== rtl/scd_pkg.sv =====
// Shared types, constants and helper functions for the streaming community detector.
// Used by every module of the block but scd_ram; depends on nothing else.
package scd_pkg;

  localparam int unsigned NODE_BITS   = 16;
  localparam int unsigned DEGREE_BITS = 16;
  localparam int unsigned FIELD_BITS  = 16;
  localparam int unsigned THRESH_BITS = 16;
  localparam int unsigned THRESH_RESET = 16;

  localparam longint unsigned NODE_COUNT = 64'd1 << NODE_BITS;
  localparam int unsigned ENTRY_BITS = DEGREE_BITS + NODE_BITS;
  localparam int unsigned CMP_BITS = (DEGREE_BITS > THRESH_BITS) ? DEGREE_BITS : THRESH_BITS;

  localparam int unsigned QUEUE_DEPTH    = 2;
  localparam int unsigned QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);

  typedef logic [NODE_BITS-1:0]      node_t;
  typedef logic [DEGREE_BITS-1:0]    degree_t;
  typedef logic [FIELD_BITS-1:0]     field_t;
  typedef logic [THRESH_BITS-1:0]    thresh_t;
  typedef logic [CMP_BITS-1:0]       cmp_t;
  typedef logic [QUEUE_PTR_BITS-1:0] qptr_t;
  typedef logic [QUEUE_PTR_BITS:0]   qcount_t;

  localparam degree_t DEGREE_MAX = '1;

  typedef struct packed {
    degree_t degree;
    node_t   community;
  } entry_t;

  typedef struct packed {
    node_t src;
    node_t dst;
    logic  self_loop;
  } item_t;

  typedef enum logic [1:0] {
    EDGE_MOVE = 2'd0,
    EDGE_LINK = 2'd1,
    EDGE_NULL = 2'd2
  } edge_class_e;

  function automatic degree_t raise_degree(degree_t d);
    return (d == DEGREE_MAX) ? d : d + degree_t'(1);
  endfunction

  function automatic logic above_threshold(degree_t d, thresh_t t);
    return cmp_t'(d) > cmp_t'(t);
  endfunction

endpackage

// ===== rtl/scd_ram.sv =====
// Generic single-write, dual-read RAM with registered read data.
// Stands alone; used for the node table of the community detector.
module scd_ram #(
  parameter int unsigned     Width = 8,
  parameter longint unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_a_i,
  input  logic [$clog2(Depth)-1:0] raddr_b_i,
  output logic [Width-1:0]         rdata_a_o,
  output logic [Width-1:0]         rdata_b_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_a_o <= mem[raddr_a_i];
      rdata_b_o <= mem[raddr_b_i];
    end
  end

endmodule

// ===== rtl/scd_front.sv =====
// Front end: accepts edges, reduces node ids, flags self loops and queues them.
// Depends on scd_pkg.
module scd_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  scd_pkg::field_t       src_node_i,
  input  scd_pkg::field_t       dst_node_i,
  input  logic                  clearing_i,
  output logic                  item_valid_o,
  input  logic                  item_ready_i,
  output scd_pkg::item_t        item_o
);

  localparam scd_pkg::qcount_t QueueFull = scd_pkg::qcount_t'(scd_pkg::QUEUE_DEPTH);
  localparam scd_pkg::qptr_t   QueueLast = scd_pkg::qptr_t'(scd_pkg::QUEUE_DEPTH - 1);

  scd_pkg::item_t   queue_q [scd_pkg::QUEUE_DEPTH];
  scd_pkg::qptr_t   wr_ptr_q, rd_ptr_q;
  scd_pkg::qcount_t count_q;
  scd_pkg::item_t   new_item;
  logic             push, pop;

  always_comb begin
    new_item.src       = scd_pkg::node_t'(src_node_i);
    new_item.dst       = scd_pkg::node_t'(dst_node_i);
    new_item.self_loop = (new_item.src == new_item.dst);
  end

  assign in_ready_o   = (count_q != QueueFull) && !clearing_i;
  assign item_valid_o = (count_q != '0);
  assign item_o       = queue_q[rd_ptr_q];
  assign push         = in_valid_i && in_ready_o;
  assign pop          = item_valid_o && item_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == QueueLast) ? '0 : wr_ptr_q + scd_pkg::qptr_t'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == QueueLast) ? '0 : rd_ptr_q + scd_pkg::qptr_t'(1);
      end
      if (push && !pop) begin
        count_q <= count_q + scd_pkg::qcount_t'(1);
      end else if (pop && !push) begin
        count_q <= count_q - scd_pkg::qcount_t'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= new_item;
    end
  end

endmodule

// ===== rtl/scd_back.sv =====
// Back end: clears the node table after reset, then reads, updates and writes back
// both endpoint entries of each edge and registers the result. Depends on scd_pkg, scd_ram.
module scd_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               item_valid_i,
  output logic               item_ready_o,
  input  scd_pkg::item_t     item_i,
  input  scd_pkg::thresh_t   threshold_i,
  output logic               clearing_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         edge_class_o,
  output scd_pkg::field_t    src_community_o,
  output scd_pkg::field_t    dst_community_o,
  output scd_pkg::field_t    src_degree_o,
  output scd_pkg::field_t    dst_degree_o
);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CALC,
    ST_WRD
  } state_e;

  state_e                state_q;
  scd_pkg::node_t        clr_cnt_q;
  scd_pkg::item_t        cur_q;
  logic                  fwd_valid_q;
  scd_pkg::node_t        fwd_s_node_q, fwd_d_node_q;
  scd_pkg::entry_t       fwd_s_q, fwd_d_q;
  logic                  out_valid_q;
  scd_pkg::edge_class_e  out_class_q;
  scd_pkg::field_t       out_s_comm_q, out_d_comm_q, out_s_deg_q, out_d_deg_q;

  logic                  pop, load;
  logic                  mem_we;
  scd_pkg::node_t        mem_waddr;
  scd_pkg::entry_t       mem_wdata;
  logic [scd_pkg::ENTRY_BITS-1:0] rdata_a, rdata_b;

  scd_pkg::entry_t       old_s, old_d;
  scd_pkg::degree_t      new_s_deg, new_d_deg;
  scd_pkg::node_t        s_comm0, d_comm0, new_s_comm, new_d_comm;
  scd_pkg::edge_class_e  new_class;
  logic                  s_high, d_high;

  assign item_ready_o = (state_q == ST_IDLE) || (state_q == ST_WRD);
  assign pop          = item_valid_i && item_ready_o;
  assign load         = (state_q == ST_CALC) && (!out_valid_q || out_ready_i);
  assign clearing_o   = (state_q == ST_CLEAR);

  scd_ram #(
    .Width (scd_pkg::ENTRY_BITS),
    .Depth (scd_pkg::NODE_COUNT)
  ) u_node_ram (
    .clk_i     (clk_i),
    .we_i      (mem_we),
    .waddr_i   (mem_waddr),
    .wdata_i   (mem_wdata),
    .re_i      (pop),
    .raddr_a_i (item_i.src),
    .raddr_b_i (item_i.dst),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  // The previous edge's final entries override stale reads of the same nodes.
  always_comb begin
    priority if (fwd_valid_q && cur_q.src == fwd_d_node_q) begin
      old_s = fwd_d_q;
    end else if (fwd_valid_q && cur_q.src == fwd_s_node_q) begin
      old_s = fwd_s_q;
    end else begin
      old_s = scd_pkg::entry_t'(rdata_a);
    end
    priority if (fwd_valid_q && cur_q.dst == fwd_d_node_q) begin
      old_d = fwd_d_q;
    end else if (fwd_valid_q && cur_q.dst == fwd_s_node_q) begin
      old_d = fwd_s_q;
    end else begin
      old_d = scd_pkg::entry_t'(rdata_b);
    end
  end

  always_comb begin
    if (cur_q.self_loop) begin
      new_s_deg = scd_pkg::raise_degree(scd_pkg::raise_degree(old_s.degree));
      new_d_deg = new_s_deg;
    end else begin
      new_s_deg = scd_pkg::raise_degree(old_s.degree);
      new_d_deg = scd_pkg::raise_degree(old_d.degree);
    end
    s_comm0 = (old_s.degree != '0) ? old_s.community : cur_q.src;
    d_comm0 = (old_d.degree != '0) ? old_d.community : cur_q.dst;
    s_high  = scd_pkg::above_threshold(new_s_deg, threshold_i);
    d_high  = scd_pkg::above_threshold(new_d_deg, threshold_i);
    new_s_comm = s_comm0;
    new_d_comm = d_comm0;
    priority if (!s_high && !d_high) begin
      new_class = scd_pkg::EDGE_MOVE;
      if (new_s_deg > new_d_deg) begin
        new_d_comm = s_comm0;
      end else begin
        new_s_comm = d_comm0;
      end
    end else if (s_high && d_high) begin
      new_class = scd_pkg::EDGE_LINK;
    end else begin
      new_class = scd_pkg::EDGE_NULL;
    end
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = clr_cnt_q;
    mem_wdata = '0;
    unique case (state_q)
      ST_CLEAR: begin
        mem_we = 1'b1;
      end
      ST_CALC: begin
        mem_we              = load;
        mem_waddr           = cur_q.src;
        mem_wdata.degree    = new_s_deg;
        mem_wdata.community = new_s_comm;
      end
      ST_WRD: begin
        mem_we    = 1'b1;
        mem_waddr = fwd_d_node_q;
        mem_wdata = fwd_d_q;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_cnt_q   <= '0;
      fwd_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      unique case (state_q)
        ST_CLEAR: begin
          clr_cnt_q <= clr_cnt_q + scd_pkg::node_t'(1);
          if (clr_cnt_q == '1) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (pop) begin
            state_q <= ST_CALC;
          end
        end
        ST_CALC: begin
          if (load) begin
            state_q <= ST_WRD;
          end
        end
        ST_WRD: begin
          state_q <= pop ? ST_CALC : ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
      if (pop) begin
        cur_q <= item_i;
      end
      if (load) begin
        fwd_valid_q  <= 1'b1;
        fwd_s_node_q <= cur_q.src;
        fwd_d_node_q <= cur_q.dst;
        fwd_s_q      <= '{degree: new_s_deg, community: new_s_comm};
        fwd_d_q      <= '{degree: new_d_deg, community: new_d_comm};
        out_valid_q  <= 1'b1;
        out_class_q  <= new_class;
        out_s_comm_q <= scd_pkg::field_t'(new_s_comm);
        out_d_comm_q <= scd_pkg::field_t'(new_d_comm);
        out_s_deg_q  <= scd_pkg::field_t'(new_s_deg);
        out_d_deg_q  <= scd_pkg::field_t'(new_d_deg);
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign edge_class_o    = out_class_q;
  assign src_community_o = out_s_comm_q;
  assign dst_community_o = out_d_comm_q;
  assign src_degree_o    = out_s_deg_q;
  assign dst_degree_o    = out_d_deg_q;

  a_pop_then_calc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |=> state_q == ST_CALC)
    else $error("An accepted edge did not move on to the update step.");

  a_load_then_dst_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> (state_q == ST_WRD && mem_we && mem_waddr == $past(cur_q.dst)))
    else $error("The destination entry was not written after the result.");

  a_degrees_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |-> (new_s_deg != '0 && new_d_deg != '0))
    else $error("An updated degree is zero.");

  a_self_loop_agrees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && cur_q.self_loop) |-> (new_s_deg == new_d_deg && new_s_comm == new_d_comm))
    else $error("A self loop gave different entries for its two endpoints.");

  a_no_accept_while_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing_o |-> (!pop && !out_valid_q))
    else $error("Edge activity during the table clear.");

endmodule

// ===== rtl/streaming_community_detect.sv =====
// Top level of the streaming community detector: threshold register, front and back end.
// Depends on scd_pkg, scd_front, scd_back (and scd_ram through scd_back).
// After reset the block clears its node table, one entry per cycle, all 2^NODE_BITS entries
// (65536 at 16-bit node ids), and holds in_ready_o low during that time. The back end then
// takes a new edge only once the last one has left the update step: the node table has a single
// write port, and each edge writes back two entries, its source and its destination. An edge
// passes through the input queue, the registered table read and the output register. The two-entry
// input queue and the output register let either side stall without holding up the other.
module streaming_community_detect (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  scd_pkg::thresh_t        cfg_wdata_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  scd_pkg::field_t         src_node_i,
  input  scd_pkg::field_t         dst_node_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [1:0]              edge_class_o,
  output scd_pkg::field_t         src_community_o,
  output scd_pkg::field_t         dst_community_o,
  output scd_pkg::field_t         src_degree_o,
  output scd_pkg::field_t         dst_degree_o
);

  scd_pkg::thresh_t threshold_q;
  scd_pkg::item_t   item;
  logic             item_valid, item_ready, clearing;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= scd_pkg::thresh_t'(scd_pkg::THRESH_RESET);
    end else if (cfg_we_i) begin
      threshold_q <= cfg_wdata_i;
    end
  end

  scd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .src_node_i   (src_node_i),
    .dst_node_i   (dst_node_i),
    .clearing_i   (clearing),
    .item_valid_o (item_valid),
    .item_ready_i (item_ready),
    .item_o       (item)
  );

  scd_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .item_valid_i    (item_valid),
    .item_ready_o    (item_ready),
    .item_i          (item),
    .threshold_i     (threshold_q),
    .clearing_o      (clearing),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .edge_class_o    (edge_class_o),
    .src_community_o (src_community_o),
    .dst_community_o (dst_community_o),
    .src_degree_o    (src_degree_o),
    .dst_degree_o    (dst_degree_o)
  );

endmodule
